>>> rtl/dmd_pkg.sv
// Package: shared types and constants of the packet decapsulator.
`timescale 1ns / 1ps
package dmd_pkg;

  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_SIGNATURE = 2'd1;
  localparam logic [1:0] KIND_SUMMARY   = 2'd2;

  localparam logic [2:0] ST_SUCCESS   = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOT_ENCAP = 3'd2;
  localparam logic [2:0] ST_VERSION   = 3'd3;
  localparam logic [2:0] ST_DECODE    = 3'd4;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_VERSION = 3'd4;
  localparam logic [2:0] REG_RCP     = 3'd5;
  localparam logic [2:0] REG_SIG     = 3'd6;

  localparam logic [7:0] MAGIC_B = 8'h42;
  localparam logic [7:0] MAGIC_C = 8'h43;
  localparam logic [7:0] MAGIC_Z = 8'h00;

  localparam int MSG_HDR_BYTES = 22;
  localparam int KEY_BYTES     = 32;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  status;
    logic [7:0]  msg_version;
    logic [7:0]  msg_type;
    logic [7:0]  hop_limit;
    logic [63:0] msg_time;
    logic [7:0]  msg_flags;
    logic [11:0] payload_length;
    logic [63:0] sender_id;
    logic [63:0] recipient_id;
    logic        recipient_present;
    logic [1:0]  item_kind;
  } dmd_out_t;

  // Entry passed from the parser to the emitter.
  typedef struct packed {
    logic     emit_byte;
    logic     emit_summary;
    dmd_out_t data_item;
    dmd_out_t summary;
  } dmd_cmd_t;

endpackage

>>> rtl/dmd_stream_if.sv
// Interface: valid/ready stream channel carrying one payload type.
`timescale 1ns / 1ps
interface dmd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dmd_in_t_def.sv
// Input item type of the packet decapsulator.
`timescale 1ns / 1ps
package dmd_in_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       frame_ok;
  } dmd_in_t;
endpackage

>>> rtl/dmd_parser.sv
// Front end: envelope checks, decryption and message header capture.
`timescale 1ns / 1ps
module dmd_parser import dmd_pkg::*; #(
  parameter int MAX_PAYLOAD     = 2048,
  parameter int ENV_BYTES       = 8,
  parameter int SIGNATURE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        frame_ok_i,
  input  logic [63:0] key_word_i [4],
  input  logic [7:0]  expected_version_i,
  input  logic [7:0]  recipient_flag_mask_i,
  input  logic [7:0]  signature_flag_mask_i,
  output dmd_cmd_t    cmd_o
);
  localparam int Capacity   = MAX_PAYLOAD + MSG_HDR_BYTES;
  localparam int CountLimit = ENV_BYTES + Capacity + 1;
  localparam int CW         = $clog2(CountLimit + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]  pst_q, pst_d;
  logic [15:0] olen_q, olen_d;
  logic [7:0]  hver_q, hver_d, htyp_q, htyp_d, hhop_q, hhop_d, hflg_q, hflg_d;
  logic [63:0] htime_q, htime_d, snd_q, snd_d, rcp_q, rcp_d;
  logic [15:0] hlen_q, hlen_d;
  logic        rseen_q, rseen_d;

  logic [17:0] d, p, s;
  logic [7:0]  v, kb;
  logic [4:0]  kidx;
  logic        fits, has_rcp, has_sig;
  logic [2:0]  status;
  logic [17:0] got;
  logic [CW-1:0] cnt_inc;
  dmd_out_t    item, summ;

  always_comb begin
    d       = 18'(cnt_q) - 18'(ENV_BYTES);
    kidx    = d[4:0];
    kb      = key_word_i[kidx[4:3]][{kidx[2:0], 3'b000} +: 8];
    v       = data_byte_i ^ kb;
    p       = 18'(MSG_HDR_BYTES) + 18'(hlen_q);
    fits    = (pst_q == ST_SUCCESS) && (hlen_q <= 16'(MAX_PAYLOAD)) &&
              (olen_q >= 16'(MSG_HDR_BYTES)) && (p <= 18'(olen_q));
    has_rcp = ((hflg_q & recipient_flag_mask_i) != 8'd0) && (p + 18'd8 <= 18'(olen_q));
    s       = p + (has_rcp ? 18'd8 : 18'd0);
    has_sig = ((hflg_q & signature_flag_mask_i) != 8'd0) &&
              (s + 18'(SIGNATURE_BYTES) <= 18'(olen_q));

    cnt_d = cnt_q; pst_d = pst_q; olen_d = olen_q; hver_d = hver_q;
    htyp_d = htyp_q; hhop_d = hhop_q; htime_d = htime_q; hflg_d = hflg_q;
    hlen_d = hlen_q; snd_d = snd_q; rcp_d = rcp_q; rseen_d = rseen_q;
    item = '0;
    cmd_o = '0;

    if (cnt_q < CW'(4)) begin
      if (data_byte_i != ((cnt_q == CW'(0)) ? MAGIC_B :
                          (cnt_q == CW'(1)) ? MAGIC_C : MAGIC_Z) &&
          pst_q == ST_SUCCESS) begin
        pst_d = ST_NOT_ENCAP;
      end
    end else if (cnt_q == CW'(4)) begin
      if (data_byte_i != expected_version_i && pst_q == ST_SUCCESS) pst_d = ST_VERSION;
    end else if (cnt_q == CW'(6)) begin
      olen_d = {data_byte_i, olen_q[7:0]};
    end else if (cnt_q == CW'(7)) begin
      olen_d = {olen_q[15:8], data_byte_i};
    end else if (cnt_q >= CW'(ENV_BYTES) && d < 18'(Capacity)) begin
      if (d == 18'd0) hver_d = v;
      else if (d == 18'd1) htyp_d = v;
      else if (d == 18'd2) hhop_d = v;
      else if (d <= 18'd10) htime_d = {htime_q[55:0], v};
      else if (d == 18'd11) hflg_d = v;
      else if (d == 18'd12) hlen_d = {v, hlen_q[7:0]};
      else if (d == 18'd13) hlen_d = {hlen_q[15:8], v};
      else if (d < 18'(MSG_HDR_BYTES)) snd_d = snd_q | (64'(v) << {d[2:0] - 3'd6, 3'b000});
      else if (fits) begin
        if (d < p) begin
          cmd_o.emit_byte = 1'b1;
          item.item_kind  = KIND_PAYLOAD;
          item.byte_value = v;
        end else if (has_rcp && d < p + 18'd8) begin
          rcp_d = rcp_q | (64'(v) << {d[2:0] - p[2:0], 3'b000});
          if (d == p + 18'd7) rseen_d = 1'b1;
        end else if (has_sig && d >= s && d < s + 18'(SIGNATURE_BYTES)) begin
          cmd_o.emit_byte = 1'b1;
          item.item_kind  = KIND_SIGNATURE;
          item.byte_value = v;
        end
      end
    end
    cnt_inc = (cnt_q < CW'(CountLimit)) ? cnt_q + CW'(1) : cnt_q;
    cnt_d = cnt_inc;

    got = 18'(cnt_inc) - 18'(ENV_BYTES);
    if (got > 18'(Capacity)) got = 18'(Capacity);
    if (!frame_ok_i || cnt_inc < CW'(ENV_BYTES)) status = ST_INVALID;
    else if (pst_d != ST_SUCCESS) status = pst_d;
    else if (18'(olen_d) > got || !((hlen_d <= 16'(MAX_PAYLOAD)) &&
             (olen_d >= 16'(MSG_HDR_BYTES)) &&
             (18'(MSG_HDR_BYTES) + 18'(hlen_d) <= 18'(olen_d)))) status = ST_DECODE;
    else status = ST_SUCCESS;

    summ = '0;
    summ.item_kind = KIND_SUMMARY;
    summ.status    = status;
    if (status == ST_SUCCESS) begin
      summ.msg_version       = hver_d;
      summ.msg_type          = htyp_d;
      summ.hop_limit         = hhop_d;
      summ.msg_time          = htime_d;
      summ.msg_flags         = hflg_d;
      summ.payload_length    = hlen_d[11:0];
      summ.sender_id         = snd_d;
      summ.recipient_id      = rseen_d ? rcp_d : 64'd0;
      summ.recipient_present = rseen_d;
    end
    cmd_o.data_item    = item;
    cmd_o.summary      = summ;
    cmd_o.emit_summary = last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; pst_q <= '0; olen_q <= '0; hver_q <= '0; htyp_q <= '0;
      hhop_q <= '0; htime_q <= '0; hflg_q <= '0; hlen_q <= '0; snd_q <= '0;
      rcp_q <= '0; rseen_q <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        cnt_q <= '0; pst_q <= '0; olen_q <= '0; hver_q <= '0; htyp_q <= '0;
        hhop_q <= '0; htime_q <= '0; hflg_q <= '0; hlen_q <= '0; snd_q <= '0;
        rcp_q <= '0; rseen_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d; pst_q <= pst_d; olen_q <= olen_d; hver_q <= hver_d;
        htyp_q <= htyp_d; hhop_q <= hhop_d; htime_q <= htime_d; hflg_q <= hflg_d;
        hlen_q <= hlen_d; snd_q <= snd_d; rcp_q <= rcp_d; rseen_q <= rseen_d;
      end
    end
  end
endmodule

>>> rtl/dmd_emitter.sv
// Back end: command queue and sequencing of up to two results per entry.
`timescale 1ns / 1ps
module dmd_emitter import dmd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dmd_cmd_t cmd_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dmd_out_t out_data_o
);
  dmd_cmd_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       sent_q;
  dmd_cmd_t   head;
  logic       pop, fire, need_byte;

  assign head        = mem_q[rp_q];
  assign full_o      = cnt_q == 2'd2;
  assign need_byte   = head.emit_byte && !sent_q;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = need_byte ? head.data_item : head.summary;
  assign fire        = out_valid_o && out_ready_i;
  assign pop         = fire && !(need_byte && head.emit_summary);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0; sent_q <= 1'b0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
      if (pop) sent_q <= 1'b0;
      else if (fire) sent_q <= 1'b1;
    end
  end
endmodule

>>> rtl/dm_packet_decapsulator.sv
// Top level: packet decapsulator with parser front end and result queue.
// Each result is registered in the result queue before it is offered.
// Input: one byte per cycle unless the queue is full; a byte with a data
// result and a summary gives both, data first. Reset clears all packet
// state and sets registers to their defaults; no clearing pass.
`timescale 1ns / 1ps
module dm_packet_decapsulator import dmd_pkg::*; import dmd_in_pkg::*; #(
  parameter int MAX_PAYLOAD     = 2048,
  parameter int ENV_BYTES       = 8,
  parameter int SIGNATURE_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmd_stream_if.sink  in_if,
  dmd_stream_if.source out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  logic [63:0] key_q [4];
  logic [7:0]  ver_q, rmask_q, smask_q;
  logic        full, step;
  dmd_cmd_t    cmd;
  dmd_in_t     in_d;

  assign in_d     = in_if.data;
  assign in_if.ready = !full;
  assign step     = in_if.valid && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '{default: '0}; ver_q <= 8'd1; rmask_q <= 8'd1; smask_q <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0:    key_q[0] <= cfg_wdata_i;
        REG_KEY1:    key_q[1] <= cfg_wdata_i;
        REG_KEY2:    key_q[2] <= cfg_wdata_i;
        REG_KEY3:    key_q[3] <= cfg_wdata_i;
        REG_VERSION: ver_q <= cfg_wdata_i[7:0];
        REG_RCP:     rmask_q <= cfg_wdata_i[7:0];
        REG_SIG:     smask_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  dmd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD), .ENV_BYTES(ENV_BYTES), .SIGNATURE_BYTES(SIGNATURE_BYTES)
  ) u_parser (
    .clk_i, .rst_ni, .step_i(step), .data_byte_i(in_d.data_byte),
    .last_byte_i(in_d.last_byte), .frame_ok_i(in_d.frame_ok), .key_word_i(key_q),
    .expected_version_i(ver_q), .recipient_flag_mask_i(rmask_q),
    .signature_flag_mask_i(smask_q), .cmd_o(cmd)
  );

  dmd_emitter u_emitter (
    .clk_i, .rst_ni, .push_i(step && (cmd.emit_byte || cmd.emit_summary)),
    .cmd_i(cmd), .full_o(full), .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule

>>> rtl/dmd_checker.sv
// Checker: port-level properties of the packet decapsulator, bound to the top.
`timescale 1ns / 1ps
module dmd_checker import dmd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid,
  input logic     out_ready,
  input dmd_out_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.item_kind != 2'd3) else $error("bad kind");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.item_kind == KIND_SUMMARY |-> out_data.byte_value == 8'd0)
    else $error("summary byte");
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != ST_SUCCESS |-> out_data.sender_id == 64'd0 &&
    !out_data.recipient_present) else $error("fail fields");
endmodule

bind dm_packet_decapsulator dmd_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_if.valid),
  .out_ready(out_if.ready), .out_data(out_if.data)
);

>>> bench/tb_top.sv
// Testbench: byte-level checks of the packet decapsulator against a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import dmd_pkg::*;
  import dmd_in_pkg::*;

  localparam int ENV_BYTES   = 8;
  localparam int MAX_PAY     = 2048;
  localparam int SIG_BYTES   = 64;
  localparam int CAPACITY    = MAX_PAY + MSG_HDR_BYTES;
  localparam int COUNT_LIMIT = ENV_BYTES + CAPACITY + 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  dmd_stream_if #(.T(dmd_in_t))  in_if ();
  dmd_stream_if #(.T(dmd_out_t)) out_if ();

  dm_packet_decapsulator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // register copies
  logic [63:0] key_w [4];
  logic [7:0]  want_ver;
  logic [7:0]  rcp_mask;
  logic [7:0]  sig_mask;

  // packet state copy
  int          byte_cnt;
  logic [2:0]  pkt_status;
  logic [15:0] orig_len;
  logic [7:0]  hdr_ver;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_hops;
  logic [63:0] hdr_time;
  logic [7:0]  hdr_flags;
  logic [15:0] hdr_len;
  logic [63:0] sender_acc;
  logic [63:0] rcp_acc;
  logic        rcp_seen;

  dmd_out_t    expected_q[$];
  logic [7:0]  pkt_q[$];
  logic [7:0]  msg_q[$];
  int          errors;
  int          bytes_sent;
  int          cycles;
  bit          no_idle;
  int          rx_wait;
  int          hold_cnt;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] key_byte(int d);
    int k;
    k = d % KEY_BYTES;
    return key_w[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic bit header_fits();
    return pkt_status == ST_SUCCESS && hdr_len <= MAX_PAY && orig_len >= MSG_HDR_BYTES &&
           MSG_HDR_BYTES + int'(hdr_len) <= int'(orig_len);
  endfunction

  function automatic bit rcp_follows();
    return (hdr_flags & rcp_mask) != 0 &&
           MSG_HDR_BYTES + int'(hdr_len) + 8 <= int'(orig_len);
  endfunction

  task automatic clear_state();
    byte_cnt = 0; pkt_status = ST_SUCCESS; orig_len = '0;
    hdr_ver = '0; hdr_type = '0; hdr_hops = '0; hdr_time = '0; hdr_flags = '0;
    hdr_len = '0; sender_acc = '0; rcp_acc = '0; rcp_seen = 1'b0;
  endtask

  task automatic push_byte(logic [1:0] kind, logic [7:0] v);
    dmd_out_t r;
    r = '0;
    r.item_kind = kind;
    r.byte_value = v;
    expected_q.push_back(r);
  endtask

  task automatic predict_byte(logic [7:0] b, logic last, logic ok);
    int pos, d, p, s, got;
    logic [7:0] v, want;
    logic [2:0] st;
    bit has_rcp;
    dmd_out_t r;
    pos = byte_cnt;
    if (pos < 4) begin
      want = (pos == 0) ? MAGIC_B : (pos == 1) ? MAGIC_C : MAGIC_Z;
      if (b != want && pkt_status == ST_SUCCESS) pkt_status = ST_NOT_ENCAP;
    end else if (pos == 4) begin
      if (b != want_ver && pkt_status == ST_SUCCESS) pkt_status = ST_VERSION;
    end else if (pos == 6) begin
      orig_len[15:8] = b;
    end else if (pos == 7) begin
      orig_len[7:0] = b;
    end else if (pos >= ENV_BYTES && pos - ENV_BYTES < CAPACITY) begin
      d = pos - ENV_BYTES;
      v = b ^ key_byte(d);
      if (d == 0) hdr_ver = v;
      else if (d == 1) hdr_type = v;
      else if (d == 2) hdr_hops = v;
      else if (d <= 10) hdr_time = {hdr_time[55:0], v};
      else if (d == 11) hdr_flags = v;
      else if (d == 12) hdr_len[15:8] = v;
      else if (d == 13) hdr_len[7:0] = v;
      else if (d < MSG_HDR_BYTES) sender_acc[(d - 14) * 8 +: 8] = v;
      else if (header_fits()) begin
        p = MSG_HDR_BYTES + int'(hdr_len);
        has_rcp = rcp_follows();
        s = p + (has_rcp ? 8 : 0);
        if (d < p) begin
          push_byte(KIND_PAYLOAD, v);
        end else if (has_rcp && d < p + 8) begin
          rcp_acc[(d - p) * 8 +: 8] = v;
          if (d == p + 7) rcp_seen = 1'b1;
        end else if ((hdr_flags & sig_mask) != 0 && s + SIG_BYTES <= int'(orig_len) &&
                     d >= s && d < s + SIG_BYTES) begin
          push_byte(KIND_SIGNATURE, v);
        end
      end
    end
    if (byte_cnt < COUNT_LIMIT) byte_cnt++;
    if (last) begin
      if (!ok || byte_cnt < ENV_BYTES) begin
        st = ST_INVALID;
      end else if (pkt_status != ST_SUCCESS) begin
        st = pkt_status;
      end else begin
        got = byte_cnt - ENV_BYTES;
        if (got > CAPACITY) got = CAPACITY;
        st = (int'(orig_len) > got || !header_fits()) ? ST_DECODE : ST_SUCCESS;
      end
      r = '0;
      r.item_kind = KIND_SUMMARY;
      r.status = st;
      if (st == ST_SUCCESS) begin
        r.msg_version = hdr_ver;
        r.msg_type = hdr_type;
        r.hop_limit = hdr_hops;
        r.msg_time = hdr_time;
        r.msg_flags = hdr_flags;
        r.payload_length = hdr_len[11:0];
        r.sender_id = sender_acc;
        r.recipient_id = rcp_seen ? rcp_acc : '0;
        r.recipient_present = rcp_seen;
      end
      expected_q.push_back(r);
      clear_state();
    end
  endtask

  // receiver
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      out_if.ready = 1'b0;
      hold_cnt--;
    end else if (rx_wait > 0) begin
      out_if.ready = 1'b0;
      rx_wait--;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dmd_out_t e, g;
    if (rst_ni && out_if.valid && out_if.ready) begin
      g = out_if.data;
      rx_wait = no_idle ? 0 : $urandom_range(0, 19);
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: kind %0d value %0h", g.item_kind, g.byte_value);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (g.item_kind != e.item_kind) begin
          $error("item_kind: exp %0d got %0d", e.item_kind, g.item_kind); errors++;
        end
        if (g.byte_value != e.byte_value) begin
          $error("byte_value: exp %0h got %0h", e.byte_value, g.byte_value); errors++;
        end
        if (g.status != e.status) begin
          $error("status: exp %0d got %0d", e.status, g.status); errors++;
        end
        if (g.msg_version != e.msg_version) begin
          $error("msg_version: exp %0h got %0h", e.msg_version, g.msg_version); errors++;
        end
        if (g.msg_type != e.msg_type) begin
          $error("msg_type: exp %0h got %0h", e.msg_type, g.msg_type); errors++;
        end
        if (g.hop_limit != e.hop_limit) begin
          $error("hop_limit: exp %0h got %0h", e.hop_limit, g.hop_limit); errors++;
        end
        if (g.msg_time != e.msg_time) begin
          $error("msg_time: exp %0h got %0h", e.msg_time, g.msg_time); errors++;
        end
        if (g.msg_flags != e.msg_flags) begin
          $error("msg_flags: exp %0h got %0h", e.msg_flags, g.msg_flags); errors++;
        end
        if (g.payload_length != e.payload_length) begin
          $error("payload_length: exp %0d got %0d", e.payload_length, g.payload_length);
          errors++;
        end
        if (g.sender_id != e.sender_id) begin
          $error("sender_id: exp %0h got %0h", e.sender_id, g.sender_id); errors++;
        end
        if (g.recipient_id != e.recipient_id) begin
          $error("recipient_id: exp %0h got %0h", e.recipient_id, g.recipient_id); errors++;
        end
        if (g.recipient_present != e.recipient_present) begin
          $error("recipient_present: exp %0d got %0d", e.recipient_present,
                 g.recipient_present);
          errors++;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, logic ok);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) in_if.valid = 1'b0;
    repeat (gap) @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.data = '{data_byte: b, last_byte: last, frame_ok: ok};
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b, last, ok);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_packet(logic ok);
    for (int i = 0; i < pkt_q.size(); i++)
      send_byte(pkt_q[i], i == pkt_q.size() - 1, (i == pkt_q.size() - 1) ? ok : 1'($urandom));
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_w[idx[1:0]] = val;
      REG_VERSION: want_ver = val[7:0];
      REG_RCP: rcp_mask = val[7:0];
      REG_SIG: sig_mask = val[7:0];
      default: ;
    endcase
  endtask

  // hold the envelope, encrypted message, then drop trim bytes from the end
  task automatic build_packet(int plen_field, int body, logic [7:0] flags, int tail,
                              int len_delta, logic [7:0] ver, int trim);
    int l;
    msg_q.delete();
    pkt_q.delete();
    repeat (11) msg_q.push_back(8'($urandom));
    msg_q.push_back(flags);
    msg_q.push_back(8'(plen_field >> 8));
    msg_q.push_back(8'(plen_field));
    repeat (8 + body + tail) msg_q.push_back(8'($urandom));
    l = msg_q.size() + len_delta;
    if (l < 0) l = 0;
    if (l > 65535) l = 65535;
    pkt_q = '{MAGIC_B, MAGIC_C, MAGIC_Z, MAGIC_Z, ver, 8'($urandom), 8'(l >> 8), 8'(l)};
    for (int d = 0; d < msg_q.size(); d++) pkt_q.push_back(msg_q[d] ^ key_byte(d));
    repeat (trim) if (pkt_q.size() > 1) void'(pkt_q.pop_back());
  endtask

  task automatic test_envelope_errors();
    pkt_q = '{MAGIC_B};
    send_packet(1'b1);
    build_packet(0, 0, 8'h00, 0, 0, want_ver, 0);
    send_packet(1'b0);
    for (int i = 0; i < 4; i++) begin
      build_packet(1, 1, 8'h00, 0, 0, want_ver, 0);
      pkt_q[i] = pkt_q[i] ^ 8'h01;
      send_packet(1'b1);
    end
    build_packet(1, 1, 8'h00, 0, 0, want_ver + 8'd1, 0);
    send_packet(1'b1);
    build_packet(0, 0, 8'h00, 0, 0, want_ver + 8'd1, 0);
    pkt_q[0] = 8'hFF;
    send_packet(1'b1);
    pkt_q = '{MAGIC_B, MAGIC_C, MAGIC_Z, MAGIC_Z, want_ver, 8'h00, 8'h00, 8'h00};
    send_packet(1'b1);
    settle();
  endtask

  task automatic test_message_forms();
    write_reg(REG_KEY0, {$urandom, $urandom});
    write_reg(REG_KEY1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_KEY2, {$urandom, $urandom});
    write_reg(REG_KEY3, {$urandom, $urandom});
    write_reg(REG_VERSION, 64'h0000_0000_0000_00FF);
    write_reg(REG_RCP, 64'h0000_0000_0000_0080);
    write_reg(REG_SIG, 64'h0000_0000_0000_0001);
    write_reg(REG_UNUSED, 64'h5A);
    build_packet(3, 3, 8'h81, 8 + SIG_BYTES, 0, want_ver, 0);
    send_packet(1'b1);
    build_packet(2, 2, 8'h81, 8 + SIG_BYTES, -1, want_ver, 0);
    send_packet(1'b1);
    build_packet(2, 2, 8'h80, 4, 0, want_ver, 0);
    send_packet(1'b1);
    build_packet(2, 2, 8'h01, SIG_BYTES, 0, want_ver, 10);
    send_packet(1'b1);
    build_packet(65535, 1, 8'h00, 0, 0, want_ver, 0);
    send_packet(1'b1);
    build_packet(0, 0, 8'h00, 0, -1, want_ver, 0);
    send_packet(1'b1);
    build_packet(4, 4, 8'h00, 0, 3, want_ver, 0);
    send_packet(1'b1);
    settle();
  endtask

  task automatic test_max_payload();
    no_idle = 1'b1;
    build_packet(MAX_PAY, MAX_PAY, 8'h00, 0, 0, want_ver, 0);
    send_packet(1'b1);
    build_packet(MAX_PAY, MAX_PAY, 8'hFF, 8 + SIG_BYTES, 0, want_ver, 0);
    send_packet(1'b1);
    settle();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cnt = 400;
    no_idle = 1'b1;
    build_packet(100, 100, 8'h00, 0, 0, want_ver, 0);
    send_packet(1'b1);
    no_idle = 1'b0;
    settle();
  endtask

  task automatic test_random();
    int plen, tail, phase;
    logic [7:0] setting [4];
    setting = '{8'h00, 8'hFF, 8'h01, 8'h80};
    phase = 0;
    while (bytes_sent < 1300 + 5000) begin
      if (bytes_sent > phase * 250 + 5000) begin
        settle();
        phase++;
        write_reg(REG_KEY0, {$urandom, $urandom});
        write_reg(REG_KEY1, {$urandom, $urandom});
        write_reg(REG_KEY2, (phase % 2) ? '0 : {$urandom, $urandom});
        write_reg(REG_KEY3, {$urandom, $urandom});
        write_reg(REG_VERSION, 64'(setting[phase % 4]));
        write_reg(REG_RCP, ($urandom_range(0, 3) == 0) ? 64'(setting[phase % 4])
                                                        : 64'(8'($urandom)));
        write_reg(REG_SIG, ($urandom_range(0, 3) == 0) ? 64'(setting[(phase + 1) % 4])
                                                        : 64'(8'($urandom)));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 8) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
        tail = $urandom_range(0, 1) * 8 + (($urandom_range(0, 3) == 0) ? SIG_BYTES : 0);
        build_packet(plen, plen, 8'($urandom), tail,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) - 5 : 0,
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : want_ver,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0);
        if ($urandom_range(0, 9) == 0)
          pkt_q[$urandom_range(0, pkt_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end else begin
        pkt_q.delete();
        repeat ($urandom_range(1, 30)) pkt_q.push_back(8'($urandom));
      end
      send_packet($urandom_range(0, 9) != 0);
    end
    settle();
  endtask

  initial begin
    errors = 0; bytes_sent = 0; cycles = 0; no_idle = 1'b0; rx_wait = 0; hold_cnt = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = REG_KEY0; cfg_wdata_i = '0;
    in_if.valid = 1'b0; in_if.data = '0;
    out_if.ready = 1'b0;
    key_w = '{default: '0};
    want_ver = 8'd1; rcp_mask = 8'd1; sig_mask = 8'd2;
    clear_state();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_envelope_errors();
    test_message_forms();
    test_max_payload();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
